### src/ptss_pkg.sv
// Shared types and constants of the periodic transmit slot scheduler.
`default_nettype none
package ptss_pkg;

  localparam int TimeWidth = 44;
  localparam int RemWidth  = 27;
  localparam int PerWidth  = 31;
  localparam logic [RemWidth-1:0] DayMs  = 27'd86400000;
  localparam logic [RemWidth-1:0] HourMs = 27'd3600000;
  localparam logic [23:0] AllHours = 24'hFFFFFF;
  // 2^TimeWidth modulo one day, worked out at elaboration
  localparam longint unsigned WrapRem = (64'd1 << TimeWidth) % 64'd86400000;
  localparam logic [RemWidth-1:0] WrapFix = RemWidth'(64'd86400000 - WrapRem);
  // 2^RemWidth modulo one day: weight of the bits folded down
  localparam logic [RemWidth-1:0] FoldC = RemWidth'((64'd1 << RemWidth) - 64'd86400000);

  typedef enum logic [2:0] {
    OP_SCHED   = 3'd0,
    OP_SET_EAR = 3'd1,
    OP_SCHED_AT = 3'd2,
    OP_TX_DONE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PMOD, ST_DIVE, ST_CHKE, ST_LOADP, ST_DIVP, ST_SRCH, ST_OUT
  } state_t;

  typedef struct packed {
    logic pmod_step;
    logic drop_ear;
    logic set_start_e;
    logic set_start_p;
    logic div_step;
    logic srch_step;
    logic commit;
    logic miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pmod_done;
    logic ear_valid;
    logic ear_ahead;
    logic div_done;
    logic hour_ok;
    logic not_before;
    logic over_day;
    logic period_zero;
    logic out_busy;
  } stat_t;

  function automatic logic hour_ok(input logic [RemWidth-1:0] r, input logic [23:0] mask);
    logic ok;
    logic [RemWidth-1:0] lo;
    ok = 1'b0;
    for (int h = 0; h < 24; h++) begin
      lo = RemWidth'(h * 3600000);
      if (r >= lo && r < lo + HourMs && mask[23-h]) ok = 1'b1;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

### src/ptss_regs.sv
// APB configuration registers of the slot scheduler.
`default_nettype none
module ptss_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic [19:0]      period_s,
  output logic [23:0]      mask,
  output logic             jit_en
);
  logic [19:0] period_r;
  logic [23:0] duty_r;
  logic        jit_en_r;
  logic        legacy_r;
  logic        wr;

  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 20'd60;
      duty_r   <= ptss_pkg::AllHours;
      jit_en_r <= 1'b0;
      legacy_r <= 1'b0;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        2'd0: period_r <= cfg_pwdata[19:0];
        2'd1: duty_r   <= cfg_pwdata[23:0];
        2'd2: jit_en_r <= cfg_pwdata[0];
        2'd3: legacy_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      2'd0: cfg_prdata = {12'd0, period_r};
      2'd1: cfg_prdata = {8'd0, duty_r};
      2'd2: cfg_prdata = {31'd0, jit_en_r};
      2'd3: cfg_prdata = {31'd0, legacy_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  assign period_s = period_r;
  assign mask = legacy_r ? ptss_pkg::AllHours : duty_r;
  assign jit_en = jit_en_r;
endmodule
`default_nettype wire

### src/ptss_ctrl.sv
// Sequencer of the slot scheduler.
`default_nettype none
module ptss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [2:0]     in_op,
  input  wire logic           out_ready,
  input  wire ptss_pkg::stat_t st,
  output logic                in_ready,
  output ptss_pkg::cmd_t      cmd
);
  ptss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ptss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ptss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_op == ptss_pkg::OP_SCHED) state_nxt = ptss_pkg::ST_PMOD;
      end
      ptss_pkg::ST_PMOD: begin
        if (!st.pmod_done) begin
          cmd.pmod_step = 1'b1;
        end else if (st.ear_valid && st.ear_ahead) begin
          cmd.set_start_e = 1'b1;
          state_nxt = ptss_pkg::ST_DIVE;
        end else begin
          cmd.drop_ear = st.ear_valid;
          state_nxt = ptss_pkg::ST_LOADP;
        end
      end
      ptss_pkg::ST_DIVE: begin
        // last step loads the remainder
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = ptss_pkg::ST_CHKE;
      end
      ptss_pkg::ST_CHKE: begin
        if (st.hour_ok) begin
          cmd.commit = 1'b1;
          state_nxt = ptss_pkg::ST_OUT;
        end else begin
          state_nxt = ptss_pkg::ST_LOADP;
        end
      end
      ptss_pkg::ST_LOADP: begin
        cmd.set_start_p = 1'b1;
        state_nxt = ptss_pkg::ST_DIVP;
      end
      ptss_pkg::ST_DIVP: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = ptss_pkg::ST_SRCH;
      end
      ptss_pkg::ST_SRCH: begin
        if (st.over_day) begin
          cmd.miss = 1'b1;
          state_nxt = ptss_pkg::ST_OUT;
        end else if (st.hour_ok && st.not_before) begin
          cmd.commit = 1'b1;
          state_nxt = ptss_pkg::ST_OUT;
        end else if (st.period_zero) begin
          cmd.miss = 1'b1;
          state_nxt = ptss_pkg::ST_OUT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ptss_pkg::ST_OUT: begin
        if (!st.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = ptss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptss_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/ptss_dp.sv
// Datapath of the slot scheduler: state, day remainder unit and search.
`default_nettype none
module ptss_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_acc,
  input  wire logic [2:0]     in_op,
  input  wire logic [31:0]    in_time_s,
  input  wire logic [20:0]    in_jitter_ms,
  input  wire logic [19:0]    period_s,
  input  wire logic [23:0]    mask,
  input  wire logic           jit_en,
  input  wire logic           out_ready,
  input  wire ptss_pkg::cmd_t cmd,
  output ptss_pkg::stat_t     st,
  output logic                out_valid,
  output logic [31:0]         out_delay_ms,
  output logic                out_found
);
  localparam int TW = ptss_pkg::TimeWidth;
  localparam int RW = ptss_pkg::RemWidth;
  localparam int PW = ptss_pkg::PerWidth;

  logic          ear_v_r, last_v_r, cur_v_r, found_r, out_v_r, out_f_r;
  logic [TW-1:0] ear_r, last_r, cur_r, now_r, jit_r, start_r, div_sh_r;
  logic [RW-1:0] rem_r;
  logic [PW-1:0] pmod_r, elapsed_r;
  logic [31:0]   out_d_r;

  logic [TW-1:0] t_ms, period, p_start, e_start, step_sum;
  logic          step_wrap;
  logic [TW-1:0] fold;
  logic [RW-1:0] fold_lo;
  logic          fold_done;
  logic [RW+1:0] m_sum, m_s1;
  logic [RW-1:0] m_new;

  assign t_ms   = TW'(in_time_s) * TW'(32'd1000);
  assign period = TW'({period_s, 10'd0} - {period_s, 4'd0} - {period_s, 3'd0});

  always_comb begin
    logic [TW-1:0] cand;
    cand = last_r + period + jit_r;
    e_start = (last_v_r && ear_r < last_r) ? last_r : ear_r;
    if (!last_v_r) begin
      p_start = now_r + jit_r;
    end else begin
      p_start = ((cand + TW'(ptss_pkg::DayMs)) < now_r) ? now_r : cand;
    end
  end

  // high bits folded down by their weight modulo one day, one fold a cycle
  assign fold      = TW'(div_sh_r[TW-1:RW]) * TW'(ptss_pkg::FoldC) + TW'(div_sh_r[RW-1:0]);
  assign fold_done = div_sh_r[TW-1:RW] == '0;
  assign fold_lo   = (div_sh_r[RW-1:0] >= ptss_pkg::DayMs) ?
                     RW'(div_sh_r[RW-1:0] - ptss_pkg::DayMs) : div_sh_r[RW-1:0];

  assign {step_wrap, step_sum} = {1'b0, start_r} + {1'b0, period};
  assign m_sum = {2'b00, rem_r} + {1'b0, pmod_r[RW:0]}
               + (step_wrap ? {2'b00, ptss_pkg::WrapFix} : '0);
  assign m_s1  = (m_sum >= {2'b00, ptss_pkg::DayMs}) ? m_sum - {2'b00, ptss_pkg::DayMs}
                                                      : m_sum;
  assign m_new = (m_s1 >= {2'b00, ptss_pkg::DayMs}) ? RW'(m_s1 - {2'b00, ptss_pkg::DayMs})
                                                    : RW'(m_s1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ear_v_r  <= 1'b0;
      ear_r    <= '0;
      last_v_r <= 1'b0;
      last_r   <= '0;
      cur_v_r  <= 1'b0;
      cur_r    <= '0;
      found_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        now_r  <= t_ms;
        jit_r  <= jit_en ? TW'(signed'(in_jitter_ms)) : '0;
        pmod_r <= PW'(period);
        case (in_op)
          ptss_pkg::OP_SET_EAR: begin
            ear_r <= t_ms; ear_v_r <= 1'b1;
          end
          ptss_pkg::OP_SCHED_AT: begin
            cur_r <= t_ms; cur_v_r <= 1'b1;
          end
          ptss_pkg::OP_TX_DONE: begin
            last_r <= cur_r; last_v_r <= cur_v_r;
          end
          ptss_pkg::OP_CLEAR: begin
            ear_v_r <= 1'b0; ear_r <= '0; last_v_r <= 1'b0; last_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.pmod_step) pmod_r <= pmod_r - PW'(ptss_pkg::DayMs);
      if (cmd.drop_ear) ear_v_r <= 1'b0;
      if (cmd.set_start_e || cmd.set_start_p) begin
        start_r   <= cmd.set_start_e ? e_start : p_start;
        div_sh_r  <= cmd.set_start_e ? e_start : p_start;
        elapsed_r <= '0;
      end
      if (cmd.div_step) begin
        if (!fold_done) div_sh_r <= fold;
        else rem_r <= fold_lo;
      end
      if (cmd.srch_step) begin
        start_r   <= step_sum;
        rem_r     <= m_new;
        elapsed_r <= elapsed_r + PW'(period);
      end
      if (cmd.commit) begin
        cur_r <= start_r; cur_v_r <= 1'b1; found_r <= 1'b1;
      end
      if (cmd.miss) begin
        cur_v_r <= 1'b0; found_r <= 1'b0;
      end
      if (cmd.out_load) begin
        out_v_r <= 1'b1;
        out_f_r <= found_r;
        out_d_r <= found_r ? 32'(cur_r - now_r) : 32'd0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign st.pmod_done   = pmod_r < PW'(ptss_pkg::DayMs);
  assign st.ear_valid   = ear_v_r;
  assign st.ear_ahead   = ear_r >= now_r;
  assign st.div_done    = fold_done;
  assign st.hour_ok     = ptss_pkg::hour_ok(rem_r, mask);
  assign st.not_before  = start_r >= now_r;
  assign st.over_day    = elapsed_r > PW'(ptss_pkg::DayMs);
  assign st.period_zero = period_s == 20'd0;
  assign st.out_busy    = out_v_r;

  assign out_valid    = out_v_r;
  assign out_delay_ms = out_d_r;
  assign out_found    = out_f_r;
endmodule
`default_nettype wire

### src/periodic_tx_slot_scheduler_top.sv
// Top level of the periodic transmit slot scheduler.
// Usage:
//   Input beats (in_op, in_time_s, in_jitter_ms) enter on a valid/ready
//   channel; only a schedule op (0) gives a result beat (out_delay_ms,
//   out_found) on the output channel. The other ops update the stored
//   earliest/last/current slots in the accepting cycle. A schedule op
//   first reduces the period modulo one day, takes the start time
//   modulo one day by folding its high bits (again for the periodic
//   start if an earliest time is tried and fails its hour check),
//   then searches one period step a cycle up to one day. The search
//   loop sets the rate; one item is in work at a time.
//   The result sits in an output register; a stalled receiver holds the
//   block in its final step until the register frees, while earlier
//   results wait there untouched. Reset (synchronous, rst_n low) clears
//   all slot state and loads the registers: period 60 s, all hours
//   allowed, jitter off, legacy off. The user must write configuration
//   over the APB port only while idle; the block does not enforce it.
`default_nettype none
module periodic_tx_slot_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_time_s,
  input  wire logic [20:0] in_jitter_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_delay_ms,
  output logic             out_found,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [19:0]     period_s;
  logic [23:0]     mask;
  logic            jit_en;
  ptss_pkg::cmd_t  cmd;
  ptss_pkg::stat_t st;

  ptss_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .period_s, .mask, .jit_en
  );

  ptss_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op, .out_ready, .st, .in_ready, .cmd
  );

  ptss_dp u_dp (
    .clk, .rst_n,
    .in_acc(in_valid & in_ready),
    .in_op, .in_time_s, .in_jitter_ms, .period_s, .mask,
    .jit_en,
    .out_ready, .cmd, .st, .out_valid, .out_delay_ms, .out_found
  );
endmodule
`default_nettype wire
